// File: rtl/core/dds_pkg.sv
package dds_pkg;

   // request field widths
   localparam int MODE_W   = 1;
   localparam int INDEX_W  = 12;
   localparam int SAMPLE_W = 16;

   // register widths
   localparam int FREQ_W   = 32;
   localparam int OFFSET_W = 12;
   localparam int CTRL_W   = 16;
   localparam int ACC_W    = 32;

   // APB port: six 32-bit registers at 4*i, highest byte address 20
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   // request modes
   localparam logic [MODE_W-1:0] MODE_TICK  = 1'b0;
   localparam logic [MODE_W-1:0] MODE_WRITE = 1'b1;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_FREQ_WORD          = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PHASE_OFFSET       = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_DUAL_MODE          = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_CTRL_SINGLE        = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CTRL_CHAN_B        = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_CTRL_CHAN_A_UPDATE = 3'd5;

   // configuration seen by the datapath
   typedef struct packed {
      logic [FREQ_W-1:0]   freq_word;
      logic [OFFSET_W-1:0] phase_offset;
      logic                dual_mode;
      logic [CTRL_W-1:0]   ctrl_single;
      logic [CTRL_W-1:0]   ctrl_chan_b;
      logic [CTRL_W-1:0]   ctrl_chan_a_update;
   } cfg_type;

endpackage

// File: rtl/core/dds_req_if.sv
interface dds_req_if
   import dds_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [INDEX_W-1:0]  table_index;
   logic [SAMPLE_W-1:0] table_value;

   modport source (output valid, output mode, output table_index, output table_value,
                   input ready);
   modport sink   (input valid, input mode, input table_index, input table_value,
                   output ready);
endinterface

// File: rtl/core/dds_rsp_if.sv
interface dds_rsp_if
   import dds_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] spi_word;

   modport source (output valid, output spi_word, input ready);
   modport sink   (input valid, input spi_word, output ready);
endinterface

// File: rtl/core/dds_ram.sv
module dds_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/dds_csr.sv
module dds_csr
   import dds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];

   // register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_FREQ_WORD:          cfg_in.freq_word          = pwdata[FREQ_W-1:0];
            REG_PHASE_OFFSET:       cfg_in.phase_offset       = pwdata[OFFSET_W-1:0];
            REG_DUAL_MODE:          cfg_in.dual_mode          = pwdata[0];
            REG_CTRL_SINGLE:        cfg_in.ctrl_single        = pwdata[CTRL_W-1:0];
            REG_CTRL_CHAN_B:        cfg_in.ctrl_chan_b        = pwdata[CTRL_W-1:0];
            REG_CTRL_CHAN_A_UPDATE: cfg_in.ctrl_chan_a_update = pwdata[CTRL_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         REG_FREQ_WORD:          prdata = cfg_ff.freq_word;
         REG_PHASE_OFFSET:       prdata = CSR_DATA_W'(cfg_ff.phase_offset);
         REG_DUAL_MODE:          prdata = CSR_DATA_W'(cfg_ff.dual_mode);
         REG_CTRL_SINGLE:        prdata = CSR_DATA_W'(cfg_ff.ctrl_single);
         REG_CTRL_CHAN_B:        prdata = CSR_DATA_W'(cfg_ff.ctrl_chan_b);
         REG_CTRL_CHAN_A_UPDATE: prdata = CSR_DATA_W'(cfg_ff.ctrl_chan_a_update);
         default:                prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/dds_phase.sv
module dds_phase
   import dds_pkg::*;
#(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cfg_type                        cfg,
   input  logic                           advance,
   dds_req_if.sink                        req_chan,
   output logic                           ram_we,
   output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
   output logic [SAMPLE_W-1:0]            ram_wdata,
   output logic                           ram_re,
   output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
   output logic                           tick_valid,
   output logic [CTRL_W-1:0]              tick_ctrl
);

   localparam int AW = $clog2(TABLE_DEPTH);

   // input register
   logic                s0_valid_ff, s0_valid_in;
   logic [MODE_W-1:0]   s0_mode_ff;
   logic [INDEX_W-1:0]  s0_index_ff;
   logic [SAMPLE_W-1:0] s0_value_ff;

   // synthesizer state
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic                half_ff, half_in;

   logic [ACC_W-1:0]    acc_sum;
   logic [AW-1:0]       base_addr;
   logic [AW-1:0]       offset_addr;
   logic                is_tick;
   logic                is_write;
   logic                fire;

   assign req_chan.ready = advance;
   assign s0_valid_in    = advance ? req_chan.valid : s0_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_mode_ff  <= req_chan.mode;
         s0_index_ff <= req_chan.table_index;
         s0_value_ff <= req_chan.table_value;
      end
   end

   // accumulator step and table address
   assign acc_sum     = acc_ff + cfg.freq_word;
   assign base_addr   = acc_sum[ACC_W-1 -: AW];
   assign offset_addr = base_addr + AW'(cfg.phase_offset);

   assign is_tick  = s0_valid_ff && (s0_mode_ff == MODE_TICK);
   assign is_write = s0_valid_ff && (s0_mode_ff == MODE_WRITE);
   assign fire     = advance && is_tick;

   // channel select: B plain then A offset, or plain if single
   always_comb begin
      if (cfg.dual_mode) begin
         if (!half_ff) begin
            ram_raddr = base_addr;
            tick_ctrl = cfg.ctrl_chan_b;
         end else begin
            ram_raddr = offset_addr;
            tick_ctrl = cfg.ctrl_chan_a_update;
         end
      end else begin
         ram_raddr = base_addr;
         tick_ctrl = cfg.ctrl_single;
      end
   end

   assign acc_in  = fire ? acc_sum : acc_ff;
   assign half_in = (fire && cfg.dual_mode) ? !half_ff : half_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         half_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         half_ff <= half_in;
      end
   end

   // table load; indexes past the table are dropped
   assign ram_we     = advance && is_write && (32'(s0_index_ff) < 32'(TABLE_DEPTH));
   assign ram_waddr  = AW'(s0_index_ff);
   assign ram_wdata  = s0_value_ff;
   assign ram_re     = advance;
   assign tick_valid = is_tick;

endmodule

// File: rtl/core/dds_dual_channel_wave_generator.sv
// Dual-channel DDS. Each request is either a tick (mode 0), which steps the
// 32-bit phase accumulator by freq_word and returns one SPI word (table
// sample ORed with the DAC control word), or a table write (mode 1), which
// loads one waveform entry and returns nothing. One request is taken every
// clock while the output side does not stall; a tick's word goes through the
// input register at the accepting edge, the registered read of the waveform
// RAM with the control stage beside it, and the output register. The
// whole pipeline holds while a result waits on rsp_chan.ready, so req ready
// follows the output side. In dual mode ticks alternate: channel B on the
// plain address with ctrl_chan_b, then channel A at address plus
// phase_offset with ctrl_chan_a_update. TABLE_DEPTH must be a power of two;
// the table address is the top log2(TABLE_DEPTH) accumulator bits. Table
// entries must be written before a tick reads them; there is no clearing
// pass. Write registers only while the block is idle.
module dds_dual_channel_wave_generator
   import dds_pkg::*;
#(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   dds_req_if.sink               req_chan,
   dds_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int AW = $clog2(TABLE_DEPTH);

   cfg_type             cfg;
   logic                advance;
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [SAMPLE_W-1:0] ram_wdata;
   logic                ram_re;
   logic [AW-1:0]       ram_raddr;
   logic [SAMPLE_W-1:0] ram_rdata;
   logic                tick_valid;
   logic [CTRL_W-1:0]   tick_ctrl;

   logic                s1_valid_ff, s1_valid_in;
   logic [CTRL_W-1:0]   s1_ctrl_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_word_ff;

   // pipeline moves whenever the output slot is free or being drained
   assign advance = !rsp_valid_ff || rsp_chan.ready;

   dds_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dds_phase #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_phase (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .advance    (advance),
      .req_chan   (req_chan),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .tick_valid (tick_valid),
      .tick_ctrl  (tick_ctrl)
   );

   dds_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // stage alongside the RAM read
   assign s1_valid_in = advance ? tick_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ctrl_ff <= tick_ctrl;
      end
   end

   // output register: sample with control bits merged in
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= ram_rdata | s1_ctrl_ff;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.spi_word = rsp_word_ff;

endmodule

// File: test/dds_wave_checker.sv
// Watches the request, result and register ports of the DDS, keeps its own
// copy of the accumulator, channel toggle, registers and waveform table, and
// compares every SPI word that leaves the block with the predicted one.
module dds_wave_checker
   import dds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   dds_req_if                    req_mon,
   dds_rsp_if                    rsp_mon,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int                    error_count,
   output int                    words_pending
);

   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_BITS   = 12;

   cfg_type             cfg;
   logic [ACC_W-1:0]    phase_acc;
   logic                chan_a_next;
   logic [SAMPLE_W-1:0] wave_mem [0:TABLE_DEPTH-1];
   logic [SAMPLE_W-1:0] spi_word_q [$];

   // advance the accumulator for one tick and form the outgoing SPI word
   function automatic logic [SAMPLE_W-1:0] spi_word_for_tick();
      logic [ADDR_BITS-1:0] addr;
      logic [CTRL_W-1:0]    ctrl;
      phase_acc = phase_acc + cfg.freq_word;
      addr = phase_acc[ACC_W-1 -: ADDR_BITS];
      if (cfg.dual_mode) begin
         if (!chan_a_next) begin
            chan_a_next = 1'b1;
            ctrl = cfg.ctrl_chan_b;
         end else begin
            // channel A: offset wraps around the table
            chan_a_next = 1'b0;
            addr = addr + cfg.phase_offset;
            ctrl = cfg.ctrl_chan_a_update;
         end
      end else begin
         // single mode leaves the channel toggle where it was
         ctrl = cfg.ctrl_single;
      end
      return wave_mem[addr] | ctrl;
   endfunction

   always @(posedge clock) begin
      logic [SAMPLE_W-1:0] want;
      if (reset) begin
         cfg = '0;
         phase_acc = '0;
         chan_a_next = 1'b0;
         spi_word_q.delete();
         error_count = 0;
      end else begin
         // register write lands on the access phase
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_FREQ_WORD:          cfg.freq_word = pwdata[FREQ_W-1:0];
               REG_PHASE_OFFSET:       cfg.phase_offset = pwdata[OFFSET_W-1:0];
               REG_DUAL_MODE:          cfg.dual_mode = pwdata[0];
               REG_CTRL_SINGLE:        cfg.ctrl_single = pwdata[CTRL_W-1:0];
               REG_CTRL_CHAN_B:        cfg.ctrl_chan_b = pwdata[CTRL_W-1:0];
               REG_CTRL_CHAN_A_UPDATE: cfg.ctrl_chan_a_update = pwdata[CTRL_W-1:0];
               default: ;
            endcase
         end

         // outgoing word against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (spi_word_q.size() == 0) begin
               error_count++;
               $display("%0t: unexpected spi_word: expected none, actual %h",
                        $time, rsp_mon.spi_word);
            end else begin
               want = spi_word_q.pop_front();
               if (rsp_mon.spi_word !== want) begin
                  error_count++;
                  $display("%0t: spi_word mismatch: expected %h, actual %h",
                           $time, want, rsp_mon.spi_word);
               end
            end
         end

         // accepted request: table load or tick
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.mode == MODE_WRITE)
               wave_mem[req_mon.table_index] = req_mon.table_value;
            else
               spi_word_q.push_back(spi_word_for_tick());
         end
      end
      words_pending <= spi_word_q.size();
   end

endmodule

// File: test/dds_dual_channel_wave_generator_tb.sv
module dds_dual_channel_wave_generator_tb;
   import dds_pkg::*;

   localparam int TABLE_DEPTH    = 4096;
   localparam int ADDR_BITS      = 12;
   localparam int RANDOM_ITEMS   = 750;
   localparam int RANDOM_PHASES  = 6;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 1000;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int error_count;
   int words_pending;
   int idle_pct = 36;
   int stall_pct = 36;
   int items_sent = 0;

   // stimulus-side phase tracking, so that every tick reads a loaded entry
   cfg_type          stim_cfg = '0;
   logic [ACC_W-1:0] stim_acc = '0;
   logic             stim_chan_a_next = 1'b0;
   bit               table_loaded [0:TABLE_DEPTH-1];

   dds_req_if req_chan ();
   dds_rsp_if rsp_chan ();

   dds_dual_channel_wave_generator DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   dds_wave_checker wave_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .pready        (pready),
      .error_count   (error_count),
      .words_pending (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // random backpressure on the SPI word side
   always @(posedge clock)
      rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);

   // watchdog: too long without any handshake ends the run
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) || psel)
            quiet = 0;
         else
            quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input cfg_type setting);
      csr_write(REG_FREQ_WORD, setting.freq_word);
      csr_write(REG_PHASE_OFFSET, CSR_DATA_W'(setting.phase_offset));
      csr_write(REG_DUAL_MODE, CSR_DATA_W'(setting.dual_mode));
      csr_write(REG_CTRL_SINGLE, CSR_DATA_W'(setting.ctrl_single));
      csr_write(REG_CTRL_CHAN_B, CSR_DATA_W'(setting.ctrl_chan_b));
      csr_write(REG_CTRL_CHAN_A_UPDATE, CSR_DATA_W'(setting.ctrl_chan_a_update));
      stim_cfg = setting;
   endtask

   // present one request, with random idle cycles ahead of it
   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic [INDEX_W-1:0] index,
                               input logic [SAMPLE_W-1:0] value);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.mode        <= mode;
      req_chan.table_index <= index;
      req_chan.table_value <= value;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic send_write(input logic [INDEX_W-1:0] index,
                             input logic [SAMPLE_W-1:0] value);
      send_request(MODE_WRITE, index, value);
      table_loaded[index] = 1'b1;
   endtask

   // tick; loads the entry it will read first when that entry is still empty,
   // and sometimes reloads it right before the read
   task automatic send_tick(input logic [INDEX_W-1:0] junk_index,
                            input logic [SAMPLE_W-1:0] junk_value);
      logic [ACC_W-1:0]     acc;
      logic [ADDR_BITS-1:0] addr;
      acc = stim_acc + stim_cfg.freq_word;
      addr = acc[ACC_W-1 -: ADDR_BITS];
      if (stim_cfg.dual_mode && stim_chan_a_next)
         addr = addr + stim_cfg.phase_offset;
      if (!table_loaded[addr] || $urandom_range(0, 99) < 15)
         send_write(addr, SAMPLE_W'($urandom_range(0, 65535)));
      send_request(MODE_TICK, junk_index, junk_value);
      stim_acc = acc;
      if (stim_cfg.dual_mode)
         stim_chan_a_next = !stim_chan_a_next;
   endtask

   // stop sending, let every SPI word come out, then let the pipe empty
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CTRL_W-1:0] pick_ctrl_word();
      case ($urandom_range(0, 3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return CTRL_W'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      cfg_type setting;
      int      phase_target;
      bit      paused;

      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.mode        = MODE_TICK;
      req_chan.table_index = '0;
      req_chan.table_value = '0;
      rsp_chan.ready       = 1'b0;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      paused               = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero step: accumulator stays put; tick ignores max index/value
      setting = '0;
      configure(setting);
      send_write(12'd0, 16'h0000);
      send_write(12'hFFF, 16'hFFFF);
      send_tick(12'hFFF, 16'hFFFF);
      send_tick(12'h000, 16'h0000);
      wait_idle();

      // full-scale step wraps the accumulator to the top entry
      setting.freq_word = 32'hFFFF_FFFF;
      setting.ctrl_single = 16'h8000;
      configure(setting);
      send_tick(12'h000, 16'h0000);
      send_tick(12'hA5A, 16'h5A5A);
      wait_idle();

      // dual mode with the largest offset: B, A, B
      setting.freq_word = 32'h8000_0000;
      setting.phase_offset = 12'hFFF;
      setting.dual_mode = 1'b1;
      setting.ctrl_single = 16'h0001;
      setting.ctrl_chan_b = 16'h1000;
      setting.ctrl_chan_a_update = 16'hFFFF;
      configure(setting);
      repeat (3) send_tick(INDEX_W'($urandom_range(0, 4095)),
                           SAMPLE_W'($urandom_range(0, 65535)));
      wait_idle();

      // single mode in between keeps the channel toggle on A
      setting.dual_mode = 1'b0;
      configure(setting);
      send_tick(12'h123, 16'h4567);
      wait_idle();
      setting.dual_mode = 1'b1;
      setting.ctrl_chan_a_update = 16'h0002;
      configure(setting);
      send_tick(12'h321, 16'h7654);
      send_tick(12'h000, 16'h0000);
      wait_idle();

      // random phases, each with its own register setting
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0: setting.freq_word = 32'h0;
            1: setting.freq_word = 32'hFFFF_FFFF;
            2: setting.freq_word = $urandom();
            3: setting.freq_word = $urandom_range(1, 8) << 20;
            4: setting.freq_word = $urandom_range(0, 255);
            default: setting.freq_word = 32'h8000_0000;
         endcase
         case ($urandom_range(0, 2))
            0: setting.phase_offset = 12'd0;
            1: setting.phase_offset = 12'hFFF;
            default: setting.phase_offset = OFFSET_W'($urandom_range(0, 4095));
         endcase
         setting.dual_mode = (phase % 2 == 0) ? 1'b1 : 1'($urandom_range(0, 1));
         setting.ctrl_single = pick_ctrl_word();
         setting.ctrl_chan_b = pick_ctrl_word();
         setting.ctrl_chan_a_update = pick_ctrl_word();
         // one phase runs with no idling on either side
         idle_pct = (phase == 1) ? 0 : 36;
         stall_pct = idle_pct;
         configure(setting);

         phase_target = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
         while (items_sent < phase_target) begin
            if (phase == 3 && !paused && items_sent >= phase_target - 60) begin
               wait_idle();
               paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 25)
               send_write(INDEX_W'($urandom_range(0, 4095)),
                          SAMPLE_W'($urandom_range(0, 65535)));
            else
               send_tick(INDEX_W'($urandom_range(0, 4095)),
                         SAMPLE_W'($urandom_range(0, 65535)));
         end
         wait_idle();
      end

      if (error_count == 0 && words_pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/dds_pkg.sv
rtl/core/dds_req_if.sv
rtl/core/dds_rsp_if.sv
rtl/core/dds_ram.sv
rtl/core/dds_csr.sv
rtl/core/dds_phase.sv
rtl/core/dds_dual_channel_wave_generator.sv
test/dds_wave_checker.sv
test/dds_dual_channel_wave_generator_tb.sv
